// ===== rtl/bidi_visual_reorder_assert.svh =====
// Assertion macros used by the bidi reorder datapath.
`ifndef BIDI_VISUAL_REORDER_ASSERT_SVH
`define BIDI_VISUAL_REORDER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define BVR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bidi reorder: assertion failed");
`define BVR_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bidi reorder: assertion failed");
`else
`define BVR_ASSERT_IMP(lbl, ante, cons)
`define BVR_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/bvr_pkg.sv =====
// Shared types, constants and classification functions of the bidi reorder block.
package bvr_pkg;

    localparam int LINE_MAX_DEF = 64;
    localparam int CP_W = 21;

    typedef enum logic [1:0] {
        DIR_LTR = 2'd0,
        DIR_RTL = 2'd1,
        DIR_NEU = 2'd2
    } dir_t;

    typedef enum logic [2:0] {
        S_LOAD,
        S_P1_RD,
        S_P1_EX,
        S_P2_RD,
        S_P2_EX,
        S_EM_RD,
        S_EM_EX
    } state_t;

    typedef enum logic [1:0] {
        DP_NONE,
        DP_P1_EXEC,
        DP_P2_EXEC,
        DP_EM_EXEC
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   in_ready;
    } cmd_t;

    typedef struct packed {
        logic eol_fire;
        logic p1_last;
        logic p2_last;
        logic em_done;
        logic out_busy;
    } status_t;

    function automatic dir_t classify(input logic [CP_W-1:0] c);
        dir_t d;
        if ((c >= 21'h0600 && c <= 21'h06FF) || (c >= 21'h0750 && c <= 21'h077F) ||
            (c >= 21'hFB50 && c <= 21'hFDFF) || (c >= 21'hFE70 && c <= 21'hFEFF))
            d = DIR_RTL;
        else if (c >= 21'h30 && c <= 21'h39)
            d = DIR_LTR;
        else if (c <= 21'h20 ||
                 c inside {21'h28, 21'h29, 21'h5B, 21'h5D, 21'h2C, 21'h2E, 21'h3A,
                           21'h3B, 21'h2D, 21'h21, 21'h3F, 21'h2F, 21'h27, 21'h22})
            d = DIR_NEU;
        else
            d = DIR_LTR;
        return d;
    endfunction

    function automatic logic is_open(input logic [CP_W-1:0] c);
        return c inside {21'h28, 21'h5B};
    endfunction

    function automatic logic is_close(input logic [CP_W-1:0] c);
        return c inside {21'h29, 21'h5D};
    endfunction

endpackage

// ===== rtl/bvr_if.sv =====
// Valid/ready channel interfaces for codepoint input and glyph output.
interface bvr_in_if;
    logic                      valid;
    logic                      ready;
    logic [bvr_pkg::CP_W-1:0]  codepoint;
    logic                      end_of_line;
    modport source (output valid, output codepoint, output end_of_line, input ready);
    modport sink (input valid, input codepoint, input end_of_line, output ready);
endinterface

interface bvr_out_if;
    logic                      valid;
    logic                      ready;
    logic [bvr_pkg::CP_W-1:0]  glyph;
    logic                      final_glyph;
    logic                      overflow;
    modport source (output valid, output glyph, output final_glyph, output overflow,
                    input ready);
    modport sink (input valid, input glyph, input final_glyph, input overflow,
                  output ready);
endinterface

// ===== rtl/bvr_ctrl.sv =====
// Sequencing state machine of the bidi reorder block.
module bvr_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  bvr_pkg::status_t st,
    output bvr_pkg::cmd_t    cmd
);
    import bvr_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_LOAD:  if (st.eol_fire) state_next = S_P1_RD;
            S_P1_RD: state_next = S_P1_EX;
            S_P1_EX: state_next = st.p1_last ? S_P2_RD : S_P1_RD;
            S_P2_RD: state_next = S_P2_EX;
            S_P2_EX: state_next = st.p2_last ? S_EM_RD : S_P2_RD;
            S_EM_RD: state_next = S_EM_EX;
            S_EM_EX:
            begin
                if (!st.out_busy)
                    state_next = st.em_done ? S_LOAD : S_EM_RD;
            end
            default: state_next = S_LOAD;
        endcase
    end

    always_comb
    begin
        cmd.in_ready = 1'b0;
        cmd.op       = DP_NONE;
        case (state_reg)
            S_LOAD:  cmd.in_ready = 1'b1;
            S_P1_EX: cmd.op = DP_P1_EXEC;
            S_P2_EX: cmd.op = DP_P2_EXEC;
            S_EM_EX: if (!st.out_busy) cmd.op = DP_EM_EXEC;
            default: cmd.op = DP_NONE;
        endcase
    end

endmodule

// ===== rtl/bvr_dp.sv =====
// Line stores, pass counters, neutral resolution and output register.
`include "bidi_visual_reorder_assert.svh"
module bvr_dp #(
    parameter int LINE_MAX = bvr_pkg::LINE_MAX_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  bvr_pkg::cmd_t    cmd,
    output bvr_pkg::status_t st,
    bvr_in_if.sink           codepoints,
    bvr_out_if.source        glyphs
);
    import bvr_pkg::*;

    localparam int IW = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;
    localparam int CW = $clog2(LINE_MAX + 1);

    logic [CP_W-1:0] line_mem  [LINE_MAX];
    dir_t            dir_mem   [LINE_MAX];
    dir_t            right_mem [LINE_MAX];
    logic [IW-1:0]   start_mem [LINE_MAX];

    logic [CP_W-1:0] line_q;
    dir_t            dir_q;
    dir_t            right_q;
    logic [IW-1:0]   start_q;

    logic [CW-1:0]   fill_reg, fill_next;
    logic            dropped_reg, dropped_next;
    logic [IW-1:0]   ptr_reg, ptr_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    dir_t            rs_reg, rs_next;
    dir_t            prev_reg, prev_next;
    logic [IW-1:0]   rstart_reg, rstart_next;
    logic            fwd_reg, fwd_next;
    logic [IW-1:0]   run_end_reg, run_end_next;
    logic [IW-1:0]   run_beg_reg, run_beg_next;

    logic            out_valid_reg, out_valid_next;
    logic [CP_W-1:0] glyph_reg;
    logic            final_reg;
    logic            ovf_reg;

    logic            accept;
    logic            has_room;
    logic [CW-1:0]   fill_m1;
    logic [IW-1:0]   last_idx;
    dir_t            cls;
    logic            new_run;
    logic            em_fire;
    logic            em_last;
    logic            em_load;

    assign accept   = codepoints.valid && codepoints.ready;
    assign has_room = fill_reg < CW'(LINE_MAX);
    assign fill_m1  = fill_reg - CW'(1);
    assign last_idx = fill_m1[IW-1:0];

    assign codepoints.ready = cmd.in_ready;

    // Neutral resolution; the left side is the already resolved neighbor.
    always_comb
    begin
        cls = dir_q;
        if (dir_q == DIR_NEU)
        begin
            if (is_open(line_q))
                cls = right_q;
            else if (is_close(line_q))
                cls = prev_reg;
            else
                cls = (prev_reg == right_q) ? prev_reg : DIR_RTL;
        end
    end
    assign new_run = (ptr_reg == '0) || (cls != prev_reg);

    assign em_fire = fwd_reg || (dir_q == DIR_RTL);
    assign em_last = (cnt_reg == fill_m1);
    assign em_load = (cmd.op == DP_EM_EXEC) && em_fire;

    assign st.eol_fire = accept && codepoints.end_of_line;
    assign st.p1_last  = (ptr_reg == '0);
    assign st.p2_last  = (ptr_reg == last_idx);
    assign st.em_done  = em_fire && em_last;
    assign st.out_busy = out_valid_reg && !glyphs.ready;

    always_ff @(posedge clk)
    begin
        if (accept && has_room)
        begin
            line_mem[fill_reg[IW-1:0]] <= codepoints.codepoint;
        end
        if (accept && has_room)
        begin
            dir_mem[fill_reg[IW-1:0]] <= classify(codepoints.codepoint);
        end
        else if (cmd.op == DP_P2_EXEC)
        begin
            dir_mem[ptr_reg] <= cls;
        end
        if (cmd.op == DP_P1_EXEC)
        begin
            right_mem[ptr_reg] <= rs_reg;
        end
        if (cmd.op == DP_P2_EXEC)
        begin
            start_mem[ptr_reg] <= new_run ? ptr_reg : rstart_reg;
        end
        line_q  <= line_mem[ptr_reg];
        dir_q   <= dir_mem[ptr_reg];
        right_q <= right_mem[ptr_reg];
        start_q <= start_mem[ptr_reg];
    end

    always_comb
    begin
        fill_next    = fill_reg;
        dropped_next = dropped_reg;
        ptr_next     = ptr_reg;
        cnt_next     = cnt_reg;
        rs_next      = rs_reg;
        prev_next    = prev_reg;
        rstart_next  = rstart_reg;
        fwd_next     = fwd_reg;
        run_end_next = run_end_reg;
        run_beg_next = run_beg_reg;
        if (accept)
        begin
            if (has_room)
                fill_next = fill_reg + CW'(1);
            else
                dropped_next = 1'b1;
            if (codepoints.end_of_line)
            begin
                ptr_next = has_room ? fill_reg[IW-1:0] : last_idx;
                rs_next  = DIR_RTL;
            end
        end
        case (cmd.op)
            DP_P1_EXEC:
            begin
                if (dir_q != DIR_NEU)
                    rs_next = dir_q;
                if (ptr_reg == '0)
                    prev_next = DIR_RTL;
                else
                    ptr_next = ptr_reg - IW'(1);
            end
            DP_P2_EXEC:
            begin
                prev_next   = cls;
                rstart_next = new_run ? ptr_reg : rstart_reg;
                if (ptr_reg == last_idx)
                begin
                    cnt_next = '0;
                    fwd_next = 1'b0;
                end
                else
                begin
                    ptr_next = ptr_reg + IW'(1);
                end
            end
            DP_EM_EXEC:
            begin
                if (fwd_reg)
                begin
                    if (ptr_reg == run_end_reg)
                    begin
                        fwd_next = 1'b0;
                        ptr_next = run_beg_reg - IW'(1);
                    end
                    else
                    begin
                        ptr_next = ptr_reg + IW'(1);
                    end
                end
                else if (dir_q == DIR_RTL)
                begin
                    ptr_next = ptr_reg - IW'(1);
                end
                else
                begin
                    // An LTR run is replayed forward from its first index.
                    run_end_next = ptr_reg;
                    run_beg_next = start_q;
                    fwd_next     = 1'b1;
                    ptr_next     = start_q;
                end
                if (em_fire)
                    cnt_next = cnt_reg + CW'(1);
                if (em_fire && em_last)
                begin
                    fill_next    = '0;
                    dropped_next = 1'b0;
                end
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            dropped_reg   <= 1'b0;
            ptr_reg       <= '0;
            cnt_reg       <= '0;
            rs_reg        <= DIR_RTL;
            prev_reg      <= DIR_RTL;
            rstart_reg    <= '0;
            fwd_reg       <= 1'b0;
            run_end_reg   <= '0;
            run_beg_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            dropped_reg   <= dropped_next;
            ptr_reg       <= ptr_next;
            cnt_reg       <= cnt_next;
            rs_reg        <= rs_next;
            prev_reg      <= prev_next;
            rstart_reg    <= rstart_next;
            fwd_reg       <= fwd_next;
            run_end_reg   <= run_end_next;
            run_beg_reg   <= run_beg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !glyphs.ready;
        if (em_load)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (em_load)
        begin
            glyph_reg <= line_q;
            final_reg <= em_last;
            ovf_reg   <= dropped_reg;
        end
    end

    assign glyphs.valid       = out_valid_reg;
    assign glyphs.glyph       = glyph_reg;
    assign glyphs.final_glyph = final_reg;
    assign glyphs.overflow    = ovf_reg;

    `BVR_ASSERT_IMP(a_fill_bound, 1'b1, fill_reg <= CW'(LINE_MAX))
    `BVR_ASSERT_IMP(a_drop_full, dropped_reg, fill_reg == CW'(LINE_MAX))
    `BVR_ASSERT_IMP(a_fwd_bound, fwd_reg, ptr_reg <= run_end_reg)
    `BVR_ASSERT_NXT(a_final_clears, em_load && em_last, fill_reg == '0 && !dropped_reg)

endmodule

// ===== rtl/bidi_visual_reorder.sv =====
// Top level: a line of codepoints in logical order is reordered to visual order.
// Load: one cycle per codepoint beat. After the end-of-line beat, a backward and a
// forward resolution pass each walk every stored codepoint (one memory read port).
// Emission walks the line backward and replays each LTR run forward from its first index.
// Output beats wait in a register; a stalled sink holds the emit loop.
// rst_n clears the controller, fill count and overflow flag; line memories are not cleared.
module bidi_visual_reorder #(
    parameter int LINE_MAX = bvr_pkg::LINE_MAX_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    bvr_in_if.sink    codepoints,
    bvr_out_if.source glyphs
);
    import bvr_pkg::*;

    cmd_t    cmd;
    status_t st;

    bvr_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .st    (st),
        .cmd   (cmd)
    );

    bvr_dp #(
        .LINE_MAX (LINE_MAX)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .st         (st),
        .codepoints (codepoints),
        .glyphs     (glyphs)
    );

endmodule
